### src/hsi_pkg.sv
`timescale 1ns / 1ps
// Heater safety interlock package: beat payload types, register map and
// counter widths. No dependencies.
package hsi_pkg;

  // Width of the saturating age counters.
  localparam int unsigned AgeBits = 16;
  localparam logic [AgeBits-1:0] AgeMax = {AgeBits{1'b1}};

  // Widths of the configuration registers.
  localparam int unsigned TempW = 12;
  localparam int unsigned TickW = 16;

  // Common width for comparing an age against a tick register.
  localparam int unsigned CmpW = (AgeBits > TickW) ? AgeBits : TickW;

  // APB register map: register index is paddr[3:2].
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  localparam logic [1:0] RegMaxTemp     = 2'd0;
  localparam logic [1:0] RegLevelConfirm = 2'd1;
  localparam logic [1:0] RegLockout     = 2'd2;

  // Register reset values.
  localparam logic signed [TempW-1:0] MaxTempReset = 12'sd625;
  localparam logic [TickW-1:0] LevelConfirmReset = 16'd3000;
  localparam logic [TickW-1:0] LockoutReset = 16'd3000;

  typedef struct packed {
    logic                    heaters_enabled;
    logic                    force_disable;
    logic                    tank_dry;
    logic signed [TempW-1:0] temperature;
    logic                    want_main;
    logic                    want_aux;
  } in_item_t;

  typedef struct packed {
    logic main_on;
    logic aux_on;
    logic relays_changed;
    logic cutout;
    logic cause_not_enabled;
    logic cause_forced;
    logic cause_tank_dry;
    logic cause_over_temp;
  } out_item_t;

endpackage

### src/hsi_if.sv
`timescale 1ns / 1ps
// Heater safety interlock channel interfaces: valid/ready with payload.
// Depends on hsi_pkg for the beat types.
interface hsi_in_if import hsi_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hsi_out_if import hsi_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/heater_safety_interlock.sv
`timescale 1ns / 1ps
// Heater safety interlock top level: tick register, relay gating logic,
// result register and APB register file. Depends on hsi_pkg and hsi_if.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+--------------------------------
//   in_i     | in  | valid/ready         | enables, tank, temperature, wants
//   out_o    | out | valid/ready         | relay states, change, cutout, causes
//   APB      | in  | psel/penable/pready | max_temp, level_confirm, lockout
//
// One beat per cycle sustained while out_o.ready stays high; a beat is taken
// into the tick register, evaluated against the relay and timer state in the
// following cycle and lands in the result register once that slot is empty or draining.
// The single evaluation stage that updates relay and age state sets the rate.
// Reset (rst_ni low, async) turns both relays off, clears both age counters
// and the level-valid flag, and loads the register defaults.
// A stalled result holds in the result register; the tick register still
// takes one more beat, then in_i.ready drops until the result drains.
module heater_safety_interlock import hsi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  hsi_in_if.sink           in_i,
  hsi_out_if.source        out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // Configuration registers.
  logic signed [TempW-1:0] max_temp_q;
  logic [TickW-1:0]        level_confirm_q;
  logic [TickW-1:0]        lockout_q;

  // Tick register (input stage).
  logic     tick_valid_q;
  in_item_t tick_q;

  // Result register.
  logic      res_valid_q;
  out_item_t res_q;
  out_item_t res_d;

  // Interlock state.
  logic               main_q, main_d;
  logic               aux_q, aux_d;
  logic               lvl_valid_q, lvl_valid_d;
  logic [AgeBits-1:0] lvl_age_q, lvl_age_d;
  logic [AgeBits-1:0] sw_age_q, sw_age_d;

  logic advance;
  logic cfg_wr;
  logic over_temp;
  logic cut;
  logic confirmed;
  logic sw_inc_ready;
  logic [AgeBits-1:0] sw_age_inc;

  // ---------------------------------------------------------------------
  // APB register file. pready is tied high: every access is zero-wait.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_temp_q      <= MaxTempReset;
      level_confirm_q <= LevelConfirmReset;
      lockout_q       <= LockoutReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegMaxTemp:      max_temp_q      <= pwdata[TempW-1:0];
        RegLevelConfirm: level_confirm_q <= pwdata[TickW-1:0];
        RegLockout:      lockout_q       <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegMaxTemp:      prdata = DataW'(unsigned'(max_temp_q));
      RegLevelConfirm: prdata = DataW'(level_confirm_q);
      RegLockout:      prdata = DataW'(lockout_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake: advance the tick register into the result register whenever
  // the result slot is empty or being drained this cycle.
  // ---------------------------------------------------------------------
  assign advance    = tick_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !tick_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      tick_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      tick_q <= in_i.data;
    end
  end

  // ---------------------------------------------------------------------
  // Evaluation of one tick.
  // ---------------------------------------------------------------------
  assign over_temp = tick_q.temperature > max_temp_q;
  assign cut = !tick_q.heaters_enabled || tick_q.force_disable ||
               tick_q.tank_dry || over_temp;

  // Level timing: drop on empty, arm at zero on first safe tick, then age.
  always_comb begin
    lvl_valid_d = lvl_valid_q;
    lvl_age_d   = lvl_age_q;
    if (tick_q.tank_dry) begin
      lvl_valid_d = 1'b0;
      lvl_age_d   = '0;
    end else if (!lvl_valid_q) begin
      lvl_valid_d = 1'b1;
      lvl_age_d   = '0;
    end else if (lvl_age_q != AgeMax) begin
      lvl_age_d   = lvl_age_q + 1'b1;
    end
  end

  assign confirmed = !tick_q.tank_dry && lvl_valid_d &&
                     (CmpW'(lvl_age_d) >= CmpW'(level_confirm_q));

  // Switch age advances at the start of every tick, saturating.
  assign sw_age_inc   = (sw_age_q == AgeMax) ? sw_age_q : sw_age_q + 1'b1;
  assign sw_inc_ready = CmpW'(sw_age_inc) >= CmpW'(lockout_q);

  always_comb begin
    main_d   = main_q;
    aux_d    = aux_q;
    sw_age_d = sw_age_inc;
    res_d    = '0;
    if (cut) begin
      // Cutout bypasses every timer; restart lockout only on a real switch.
      if (main_q || aux_q) begin
        main_d   = 1'b0;
        aux_d    = 1'b0;
        sw_age_d = '0;
        res_d.relays_changed = 1'b1;
      end
    end else if (confirmed && sw_inc_ready) begin
      if ((main_q != tick_q.want_main) || (aux_q != tick_q.want_aux)) begin
        main_d   = tick_q.want_main;
        aux_d    = tick_q.want_aux;
        sw_age_d = '0;
        res_d.relays_changed = 1'b1;
      end
    end
    res_d.main_on           = main_d;
    res_d.aux_on            = aux_d;
    res_d.cutout            = cut;
    res_d.cause_not_enabled = cut && !tick_q.heaters_enabled;
    res_d.cause_forced      = cut && tick_q.force_disable;
    res_d.cause_tank_dry    = cut && tick_q.tank_dry;
    res_d.cause_over_temp   = cut && over_temp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q      <= 1'b0;
      aux_q       <= 1'b0;
      lvl_valid_q <= 1'b0;
      lvl_age_q   <= '0;
      sw_age_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        main_q      <= main_d;
        aux_q       <= aux_d;
        lvl_valid_q <= lvl_valid_d;
        lvl_age_q   <= lvl_age_d;
        sw_age_q    <= sw_age_d;
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_cut_relays_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.cutout |-> !out_o.data.main_on && !out_o.data.aux_on)
    else $error("relay on in a cutout beat");

  a_cause_needs_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.data.cause_not_enabled || out_o.data.cause_forced ||
    out_o.data.cause_tank_dry || out_o.data.cause_over_temp) |-> out_o.data.cutout)
    else $error("cutout cause without cutout");

  a_switch_restarts_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.relays_changed |=> sw_age_q == '0)
    else $error("relay switch did not restart lockout");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.main_on == main_q) && (out_o.data.aux_on == aux_q))
    else $error("result relay state differs from held state");

  a_tick_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_valid_q && !advance |=> tick_valid_q && $stable(tick_q))
    else $error("stalled tick lost");

endmodule
